// ===== design/ole_pkg.sv =====
// ole_pkg: shared types and codes for the ordered list engine.
// Used by ole_cell, ole_cell_row and ordered_list_engine. No dependencies.
`timescale 1ns / 1ps

package ole_pkg;

   typedef logic signed [31:0] value_type;

   // request modes
   typedef enum logic [2:0] {
      MODE_ADD_FRONT = 3'd0,
      MODE_ADD_END   = 3'd1,
      MODE_ADD_POS   = 3'd2,
      MODE_REM_FRONT = 3'd3,
      MODE_REM_END   = 3'd4,
      MODE_REM_POS   = 3'd5,
      MODE_SEARCH    = 3'd6,
      MODE_CLEAR     = 3'd7
   } mode_type;

   // result status
   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_BAD  = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   // operation broadcast to every cell of the row
   typedef enum logic [2:0] {
      CELL_HOLD        = 3'd0,
      CELL_INSERT      = 3'd1,
      CELL_REMOVE      = 3'd2,
      CELL_MATCH_LOAD  = 3'd3,
      CELL_MATCH_SHIFT = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      value_type   value;   // insert value or search key
   } cell_cmd_type;

endpackage

// ===== design/ordered_list_engine.sv =====
// ordered_list_engine: top level, request sequencer and result register.
// Depends on ole_pkg and ole_cell_row.
`timescale 1ns / 1ps

// An ordered list of up to CAPACITY signed 32-bit values held in a row of
// cells, one entry per cell, index 0 at the head. Inserts shift the cells
// at and behind the position one place toward the tail, removes shift them
// one place toward the head, both at once across the whole row.
// Requests are handled one at a time: accept, execute, optional search
// scan, then finish (tail read and result load). The next request is
// accepted only once the finish step has loaded the result register. A
// search adds a scan step in which the per-cell match flags are shifted
// toward the head one place a cycle until the first match reaches cell 0
// or the scan passes the last entry. A new request is accepted while the
// previous result still waits in the output register; the finish step
// waits only if that register is full and stalled. Entries are not
// cleared at reset (only the count is) and no entry at or beyond the
// count is ever reported.

module ordered_list_engine
   import ole_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_mode,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed_value,
   output logic               rsp_removed_valid,
   output logic               rsp_found,
   output logic [3:0]         rsp_found_index,
   output logic [4:0]         rsp_item_count,
   output logic               rsp_list_empty,
   output logic signed [31:0] rsp_head_value,
   output logic signed [31:0] rsp_tail_value
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);
   // address width covers both the count and the 5-bit position field
   localparam int AW    = (CNT_W > 5) ? CNT_W : 5;
   localparam logic [CNT_W-1:0] CapCount = CNT_W'(CAPACITY);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   mode_type         mode_ff;
   value_type        key_ff;
   logic [4:0]       pos_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   // per-request working results
   status_type       status_ff, status_in;
   logic             took_ff, took_in;
   value_type        taken_ff, taken_in;
   logic             found_ff, found_in;
   logic [AW-1:0]    scan_idx_ff, scan_idx_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   value_type        rsp_removed_value_ff;
   logic             rsp_removed_valid_ff;
   logic             rsp_found_ff;
   logic [3:0]       rsp_found_index_ff;
   logic [4:0]       rsp_item_count_ff;
   logic             rsp_list_empty_ff;
   value_type        rsp_head_value_ff;
   value_type        rsp_tail_value_ff;
   logic             rsp_load;

   // cell row interface
   cell_cmd_type     cmd;
   logic [AW-1:0]    op_addr;
   logic [AW-1:0]    cnt_ext;
   logic [AW-1:0]    last_addr;
   logic [IDX_W-1:0] rd_addr;
   value_type        rd_data;
   value_type        head_data;
   logic             head_match;

   logic             ins_bad, ins_full, rem_bad;
   logic             req_accept;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign cnt_ext   = AW'(count_ff);
   assign last_addr = cnt_ext - AW'(1);

   // target index of the request
   always_comb begin
      unique case (mode_ff)
         MODE_ADD_FRONT: op_addr = '0;
         MODE_ADD_END:   op_addr = cnt_ext;
         MODE_ADD_POS:   op_addr = AW'(pos_ff);
         MODE_REM_FRONT: op_addr = '0;
         MODE_REM_END:   op_addr = last_addr;
         MODE_REM_POS:   op_addr = AW'(pos_ff);
         MODE_SEARCH:    op_addr = '0;
         MODE_CLEAR:     op_addr = '0;
      endcase
   end

   // position check comes before the full check on insert
   assign ins_bad  = (op_addr > cnt_ext);
   assign ins_full = (count_ff >= CapCount);
   assign rem_bad  = (count_ff == '0) || (op_addr >= cnt_ext);

   // execute reads the target entry (removed value), finish reads the tail
   assign rd_addr = (state_ff == ST_FIN) ? last_addr[IDX_W-1:0] : op_addr[IDX_W-1:0];

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      took_in     = took_ff;
      taken_in    = taken_ff;
      found_in    = found_ff;
      scan_idx_in = scan_idx_ff;
      cmd.op      = CELL_HOLD;
      cmd.value   = key_ff;
      rsp_load    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            status_in   = STAT_OK;
            took_in     = 1'b0;
            taken_in    = rd_data;
            found_in    = 1'b0;
            scan_idx_in = '0;
            state_in    = ST_FIN;
            unique case (mode_ff) inside
               MODE_ADD_FRONT, MODE_ADD_END, MODE_ADD_POS: begin
                  if (ins_bad) begin
                     status_in = STAT_BAD;
                  end else if (ins_full) begin
                     status_in = STAT_FULL;
                  end else begin
                     cmd.op   = CELL_INSERT;
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               MODE_REM_FRONT, MODE_REM_END, MODE_REM_POS: begin
                  if (rem_bad) begin
                     status_in = STAT_BAD;
                  end else begin
                     cmd.op   = CELL_REMOVE;
                     took_in  = 1'b1;
                     count_in = count_ff - CNT_W'(1);
                  end
               end
               MODE_SEARCH: begin
                  if (count_ff != '0) begin
                     cmd.op   = CELL_MATCH_LOAD;
                     state_in = ST_SCAN;
                  end
               end
               MODE_CLEAR: begin
                  count_in = '0;
               end
            endcase
         end

         ST_SCAN: begin
            // first match arrives at cell 0 after scan_idx shifts
            if (head_match) begin
               found_in = 1'b1;
               state_in = ST_FIN;
            end else if (scan_idx_ff + AW'(1) >= cnt_ext) begin
               state_in = ST_FIN;
            end else begin
               cmd.op      = CELL_MATCH_SHIFT;
               scan_idx_in = scan_idx_ff + AW'(1);
            end
         end

         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff <= mode_type'(req_mode);
         key_ff  <= req_value;
         pos_ff  <= req_position;
      end
      status_ff   <= status_in;
      took_ff     <= took_in;
      taken_ff    <= taken_in;
      found_ff    <= found_in;
      scan_idx_ff <= scan_idx_in;
      if (rsp_load) begin
         rsp_status_ff        <= status_ff;
         rsp_removed_value_ff <= took_ff ? taken_ff : '0;
         rsp_removed_valid_ff <= took_ff;
         rsp_found_ff         <= found_ff;
         rsp_found_index_ff   <= found_ff ? scan_idx_ff[3:0] : 4'd0;
         rsp_item_count_ff    <= cnt_ext[4:0];
         rsp_list_empty_ff    <= (count_ff == '0);
         rsp_head_value_ff    <= (count_ff == '0) ? '0 : head_data;
         rsp_tail_value_ff    <= (count_ff == '0) ? '0 : rd_data;
      end
   end

   ole_cell_row #(
      .CAPACITY (CAPACITY),
      .AW       (AW),
      .IDX_W    (IDX_W)
   ) u_row (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .addr       (op_addr),
      .count      (cnt_ext),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .head_data  (head_data),
      .head_match (head_match)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_removed_value = rsp_removed_value_ff;
   assign rsp_removed_valid = rsp_removed_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_found_index   = rsp_found_index_ff;
   assign rsp_item_count    = rsp_item_count_ff;
   assign rsp_list_empty    = rsp_list_empty_ff;
   assign rsp_head_value    = rsp_head_value_ff;
   assign rsp_tail_value    = rsp_tail_value_ff;

`ifndef ASSERT_OFF
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CapCount)
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (count_ff == $past(count_ff) ||
                                 count_ff == $past(count_ff) + CNT_W'(1) ||
                                 count_ff == $past(count_ff) - CNT_W'(1) ||
                                 count_ff == '0))
      else $error("count moved by more than one entry");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_list_empty_ff) |->
         (rsp_head_value_ff == '0 && rsp_tail_value_ff == '0))
      else $error("empty list reports nonzero head or tail");

   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_removed_valid_ff) |->
         (rsp_status_ff == STAT_OK && !rsp_found_ff))
      else $error("removed value with bad status or search hit");
`endif

endmodule

// ===== design/ole_cell.sv =====
// ole_cell: one list entry plus its search match flag.
// Depends on ole_pkg; instantiated by ole_cell_row.
`timescale 1ns / 1ps

module ole_cell
   import ole_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int AW    = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  cell_cmd_type cmd,
   input  logic [AW-1:0] addr,
   input  logic [AW-1:0] count,
   input  value_type    prev_value,
   input  value_type    next_value,
   input  logic         next_match,
   output value_type    value_out,
   output logic         match_out
);

   localparam logic [AW-1:0] MyIdx = AW'(INDEX);

   value_type value_ff, value_in;
   logic      match_ff, match_in;

   always_comb begin
      value_in = value_ff;
      match_in = match_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (MyIdx == addr) begin
               value_in = cmd.value;
            end else if (MyIdx > addr) begin
               value_in = prev_value;
            end
         end
         CELL_REMOVE: begin
            if (MyIdx >= addr) begin
               value_in = next_value;
            end
         end
         CELL_MATCH_LOAD:  match_in = (MyIdx < count) && (value_ff == cmd.value);
         CELL_MATCH_SHIFT: match_in = next_match;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   assign match_out = match_ff;

endmodule

// ===== design/ole_cell_row.sv =====
// ole_cell_row: chain of ole_cell instances with one indexed read port.
// Depends on ole_pkg and ole_cell; instantiated by ordered_list_engine.
`timescale 1ns / 1ps

module ole_cell_row
   import ole_pkg::*;
#(
   parameter int CAPACITY = 16,
   parameter int AW       = 5,
   parameter int IDX_W    = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  cell_cmd_type    cmd,
   input  logic [AW-1:0]   addr,
   input  logic [AW-1:0]   count,
   input  logic [IDX_W-1:0] rd_addr,
   output value_type       rd_data,
   output value_type       head_data,
   output logic            head_match
);

   value_type cell_value [CAPACITY];
   logic      cell_match [CAPACITY];

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      value_type prev_v, next_v;
      logic      next_m;

      if (g == 0) begin : g_first
         assign prev_v = '0;
      end else begin : g_mid_prev
         assign prev_v = cell_value[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign next_v = '0;
         assign next_m = 1'b0;
      end else begin : g_mid_next
         assign next_v = cell_value[g+1];
         assign next_m = cell_match[g+1];
      end

      ole_cell #(
         .INDEX (g),
         .AW    (AW)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .addr       (addr),
         .count      (count),
         .prev_value (prev_v),
         .next_value (next_v),
         .next_match (next_m),
         .value_out  (cell_value[g]),
         .match_out  (cell_match[g])
      );
   end

   assign rd_data    = cell_value[rd_addr];
   assign head_data  = cell_value[0];
   assign head_match = cell_match[0];

endmodule

// ===== sim/tb.sv =====
// tb: self-checking testbench for ordered_list_engine.
// Depends on ole_pkg and the design sources; drives random and directed requests
// and checks every result against a list predictor kept inside the bench.
`timescale 1ns / 1ps

module tb;
   import ole_pkg::*;

   localparam int LIST_DEPTH = 16;

   // one expected result, field for field as the rsp_ ports carry it
   typedef struct {
      status_type status;
      value_type  removed_value;
      logic       removed_valid;
      logic       found;
      logic [3:0] found_index;
      logic [4:0] item_count;
      logic       list_empty;
      value_type  head_value;
      value_type  tail_value;
   } list_result_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_mode;
   logic signed [31:0] req_value;
   logic [4:0]         req_position;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_removed_value;
   logic               rsp_removed_valid;
   logic               rsp_found;
   logic [3:0]         rsp_found_index;
   logic [4:0]         rsp_item_count;
   logic               rsp_list_empty;
   logic signed [31:0] rsp_head_value;
   logic signed [31:0] rsp_tail_value;

   // predictor state: the list as the block should hold it
   value_type       list_cells[LIST_DEPTH];
   int              list_len;
   list_result_type pending_results[$];
   int              error_count;
   bit              idle_on;

   ordered_list_engine i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .req_position      (req_position),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_removed_value (rsp_removed_value),
      .rsp_removed_valid (rsp_removed_valid),
      .rsp_found         (rsp_found),
      .rsp_found_index   (rsp_found_index),
      .rsp_item_count    (rsp_item_count),
      .rsp_list_empty    (rsp_list_empty),
      .rsp_head_value    (rsp_head_value),
      .rsp_tail_value    (rsp_tail_value)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #5ms;
      $display("tb failed");
      $finish;
   end

   // --------------------------------------------------------------------
   // Predictor: applies one request to the list and returns its result.
   // --------------------------------------------------------------------
   function automatic list_result_type apply_request(mode_type m, value_type v,
                                                     logic [4:0] p);
      list_result_type r;
      int              at;
      r = '{status: STAT_OK, removed_value: '0, removed_valid: 1'b0,
            found: 1'b0, found_index: '0, item_count: '0, list_empty: 1'b0,
            head_value: '0, tail_value: '0};
      case (m) inside
         MODE_ADD_FRONT, MODE_ADD_END, MODE_ADD_POS: begin
            at = (m == MODE_ADD_FRONT) ? 0 : (m == MODE_ADD_END) ? list_len : int'(p);
            // position check wins over the full check
            if (at > list_len) begin
               r.status = STAT_BAD;
            end else if (list_len >= LIST_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               for (int i = list_len; i > at; i--) list_cells[i] = list_cells[i-1];
               list_cells[at] = v;
               list_len++;
            end
         end
         MODE_REM_FRONT, MODE_REM_END, MODE_REM_POS: begin
            at = (m == MODE_REM_FRONT) ? 0 : (m == MODE_REM_END) ? list_len - 1 : int'(p);
            if (list_len == 0 || at >= list_len) begin
               r.status = STAT_BAD;
            end else begin
               r.removed_value = list_cells[at];
               r.removed_valid = 1'b1;
               for (int i = at; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
               list_len--;
            end
         end
         MODE_SEARCH: begin
            for (int i = 0; i < list_len; i++) begin
               if (!r.found && list_cells[i] == v) begin
                  r.found       = 1'b1;
                  r.found_index = i[3:0];
               end
            end
         end
         default: list_len = 0;   // clear: count only, nothing reported
      endcase
      r.item_count = list_len[4:0];
      r.list_empty = (list_len == 0);
      if (list_len != 0) begin
         r.head_value = list_cells[0];
         r.tail_value = list_cells[list_len-1];
      end
      return r;
   endfunction

   // --------------------------------------------------------------------
   // Request driver: random gaps, then hold the request until accepted.
   // Valid stays high from one request to the next unless a gap is taken.
   // --------------------------------------------------------------------
   task automatic send_request(input mode_type m, input value_type v,
                               input logic [4:0] p);
      while (idle_on && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_mode     <= m;
      req_value    <= v;
      req_position <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(apply_request(m, v, p));
      @(negedge clock);
   endtask

   // let every outstanding result drain; a search on a full list is the
   // slowest request
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_results.size() != 0 && waited < 5000) begin
         @(negedge clock);
         waited++;
      end
      repeat (24) @(negedge clock);
   endtask

   // extremes, a tight cluster around zero so searches hit duplicates, and
   // full-range values
   function automatic value_type pick_value();
      case ($urandom_range(9)) inside
         0:       return 32'sh8000_0000;
         1:       return 32'sh7FFF_FFFF;
         [2:4]:   return value_type'($urandom_range(8)) - 32'sd4;
         default: return value_type'($urandom);
      endcase
   endfunction

   // --------------------------------------------------------------------
   // Result checker: every accepted result against the oldest expectation.
   // --------------------------------------------------------------------
   always @(negedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < 17);
   end

   always @(posedge clock) begin
      list_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with no request outstanding: status %0d count %0d",
                     $time, rsp_status, rsp_item_count);
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status ||
                rsp_removed_value !== e.removed_value ||
                rsp_removed_valid !== e.removed_valid ||
                rsp_found !== e.found ||
                rsp_found_index !== e.found_index ||
                rsp_item_count !== e.item_count ||
                rsp_list_empty !== e.list_empty ||
                rsp_head_value !== e.head_value ||
                rsp_tail_value !== e.tail_value) begin
               $display("%0t: mismatch expected st=%0d rm=%0d/%0d fd=%0d/%0d cnt=%0d emp=%0d hd=%0d tl=%0d",
                        $time, e.status, e.removed_valid, e.removed_value, e.found,
                        e.found_index, e.item_count, e.list_empty, e.head_value,
                        e.tail_value);
               $display("%0t:          actual   st=%0d rm=%0d/%0d fd=%0d/%0d cnt=%0d emp=%0d hd=%0d tl=%0d",
                        $time, rsp_status, rsp_removed_valid, rsp_removed_value, rsp_found,
                        rsp_found_index, rsp_item_count, rsp_list_empty, rsp_head_value,
                        rsp_tail_value);
               error_count++;
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------

   // empty-list errors, positional inserts, full list, deep search, clear
   task automatic test_directed();
      send_request(MODE_SEARCH, 32'sd0, 5'd0);       // search empty: not found
      send_request(MODE_REM_FRONT, 32'sd0, 5'd0);    // remove from empty list
      send_request(MODE_REM_END, 32'sd0, 5'd0);
      send_request(MODE_REM_POS, 32'sd0, 5'd0);
      send_request(MODE_ADD_POS, 32'sd7, 5'd1);      // insert past the end
      send_request(MODE_ADD_FRONT, 32'sh8000_0000, 5'd0);
      send_request(MODE_ADD_POS, 32'sh7FFF_FFFF, 5'd1);
      send_request(MODE_ADD_POS, 32'sd3, 5'd3);      // bad, count is 2
      for (int i = 0; i < LIST_DEPTH - 2; i++)
         send_request(MODE_ADD_END, value_type'(32'h5A5A_0000 | i), 5'd0);
      send_request(MODE_ADD_FRONT, 32'sd1, 5'd0);    // full list
      send_request(MODE_ADD_POS, -32'sd1, 5'd16);    // full, position still legal
      send_request(MODE_SEARCH, value_type'(32'h5A5A_000D), 5'd0);  // last cell
      send_request(MODE_REM_POS, 32'sd0, 5'd16);     // remove at count
      send_request(MODE_REM_POS, 32'sd0, 5'd5);
      send_request(MODE_REM_END, 32'sd0, 5'd0);
      send_request(MODE_REM_FRONT, 32'sd0, 5'd0);
      send_request(MODE_SEARCH, 32'sd12345, 5'd0);   // no match
      send_request(MODE_CLEAR, 32'sd0, 5'd0);
   endtask

   // mostly legal requests that walk the list between empty and full, with
   // some noise and out-of-range positions mixed in
   task automatic test_random_mix(input int n_items);
      int        sel;
      bit        grow;
      mode_type  m;
      value_type v;
      grow = 1'b1;
      for (int k = 0; k < n_items; k++) begin
         if (list_len == LIST_DEPTH)    grow = 1'b0;
         else if (list_len == 0)        grow = 1'b1;
         else if ($urandom_range(31) == 0) grow = !grow;
         sel = $urandom_range(99);
         if (sel < 8) begin
            send_request(mode_type'($urandom_range(7)), pick_value(),
                         5'($urandom_range(16)));
         end else if (sel < 22) begin
            v = (list_len > 0 && $urandom_range(1)) ?
                list_cells[$urandom_range(list_len - 1)] : pick_value();
            send_request(MODE_SEARCH, v, 5'($urandom_range(16)));
         end else if (sel < 23) begin
            send_request(MODE_CLEAR, pick_value(), 5'($urandom_range(16)));
         end else if (grow ^ ($urandom_range(3) == 0)) begin
            m = mode_type'($urandom_range(2));       // one of the inserts
            send_request(m, pick_value(), 5'($urandom_range(list_len)));
         end else begin
            m = mode_type'(MODE_REM_FRONT + $urandom_range(2));
            send_request(m, pick_value(),
                         5'(list_len > 0 ? $urandom_range(list_len - 1) : 0));
         end
      end
   endtask

   // sender holds off until the block has nothing in flight, then resumes
   task automatic test_drain_pause();
      wait_drained();
      test_random_mix(50);
   endtask

   // no gaps and no stalls on either side
   task automatic test_back_to_back();
      idle_on = 1'b0;
      test_random_mix(300);
      idle_on = 1'b1;
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = MODE_SEARCH;
      req_value    = '0;
      req_position = '0;
      rsp_stall    = 1'b0;
      error_count  = 0;
      list_len     = 0;
      idle_on      = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_mix(600);
      test_drain_pause();
      test_back_to_back();
      test_random_mix(550);
      wait_drained();

      if (pending_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
